@@ src/rau_pkg.sv @@
package rau_pkg;

   localparam int unsigned DataW = 64;
   localparam int unsigned StepW = 6;
   localparam int unsigned PcW   = 6;

   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_DIV = 3'd3;
   localparam logic [2:0] MODE_EQ  = 3'd4;
   localparam logic [2:0] MODE_LT  = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   localparam logic [2:0] R_AN = 3'd0;
   localparam logic [2:0] R_AD = 3'd1;
   localparam logic [2:0] R_BN = 3'd2;
   localparam logic [2:0] R_BD = 3'd3;
   localparam logic [2:0] R_T4 = 3'd4;
   localparam logic [2:0] R_T5 = 3'd5;
   localparam logic [2:0] R_TN = 3'd6;
   localparam logic [2:0] R_TD = 3'd7;

   localparam logic [PcW-1:0] PC_ADDSUB = 6'd0;
   localparam logic [PcW-1:0] PC_MUL    = 6'd12;
   localparam logic [PcW-1:0] PC_DIV    = 6'd24;

   localparam logic [DataW-1:0] SMIN = {1'b1, {(DataW-1){1'b0}}};
   localparam logic [DataW-1:0] SMAX = {1'b0, {(DataW-1){1'b1}}};

   typedef enum logic [2:0] {
      OP_GCD = 3'd0,
      OP_DIV = 3'd1,
      OP_MUL = 3'd2,
      OP_ADD = 3'd3,
      OP_END = 3'd4
   } uop_op_type;

   typedef struct packed {
      uop_op_type op;
      logic [2:0] d;
      logic [2:0] x;
      logic [2:0] y;
   } uop_type;

   function automatic logic [DataW-1:0] mag(input logic [DataW-1:0] v);
      mag = v[DataW-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic uop_type mk(input uop_op_type op, input logic [2:0] d,
                                  input logic [2:0] x, input logic [2:0] y);
      uop_type u;
      u.op = op;
      u.d  = d;
      u.x  = x;
      u.y  = y;
      mk = u;
   endfunction

   function automatic uop_type uop_rom(input logic [PcW-1:0] pc);
      uop_type u;
      unique case (pc)
         6'd0:  u = mk(OP_GCD, R_T4, R_AD, R_BD);
         6'd1:  u = mk(OP_DIV, R_T5, R_BD, R_T4);
         6'd2:  u = mk(OP_MUL, R_TD, R_AD, R_T5);
         6'd3:  u = mk(OP_DIV, R_T5, R_TD, R_AD);
         6'd4:  u = mk(OP_MUL, R_T5, R_AN, R_T5);
         6'd5:  u = mk(OP_DIV, R_T4, R_TD, R_BD);
         6'd6:  u = mk(OP_MUL, R_T4, R_BN, R_T4);
         6'd7:  u = mk(OP_ADD, R_TN, R_T5, R_T4);
         6'd12: u = mk(OP_GCD, R_T4, R_AN, R_BD);
         6'd13: u = mk(OP_GCD, R_T5, R_BN, R_AD);
         6'd14: u = mk(OP_DIV, R_TN, R_AN, R_T4);
         6'd15: u = mk(OP_DIV, R_TD, R_BN, R_T5);
         6'd16: u = mk(OP_MUL, R_TN, R_TN, R_TD);
         6'd17: u = mk(OP_DIV, R_TD, R_AD, R_T5);
         6'd18: u = mk(OP_DIV, R_T5, R_BD, R_T4);
         6'd19: u = mk(OP_MUL, R_TD, R_TD, R_T5);
         6'd24: u = mk(OP_GCD, R_T4, R_AN, R_BN);
         6'd25: u = mk(OP_GCD, R_T5, R_AD, R_BD);
         6'd26: u = mk(OP_DIV, R_TN, R_AN, R_T4);
         6'd27: u = mk(OP_DIV, R_TD, R_BD, R_T5);
         6'd28: u = mk(OP_MUL, R_TN, R_TN, R_TD);
         6'd29: u = mk(OP_DIV, R_TD, R_AD, R_T5);
         6'd30: u = mk(OP_DIV, R_T5, R_BN, R_T4);
         6'd31: u = mk(OP_MUL, R_TD, R_TD, R_T5);
         6'd8, 6'd20, 6'd32:  u = mk(OP_GCD, R_T4, R_TN, R_TD);
         6'd9, 6'd21, 6'd33:  u = mk(OP_DIV, R_TN, R_TN, R_T4);
         6'd10, 6'd22, 6'd34: u = mk(OP_DIV, R_TD, R_TD, R_T4);
         default: u = mk(OP_END, R_TN, R_TN, R_TD);
      endcase
      uop_rom = u;
   endfunction

endpackage

@@ src/rau_req_if.sv @@
interface rau_req_if;
   import rau_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [2:0]              mode;
   logic signed [DataW-1:0] a_num;
   logic signed [DataW-1:0] a_den;
   logic signed [DataW-1:0] b_num;
   logic signed [DataW-1:0] b_den;
   modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

@@ src/rau_rsp_if.sv @@
interface rau_rsp_if;
   import rau_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [DataW-1:0] result_num;
   logic signed [DataW-1:0] result_den;
   logic                    compare_true;
   logic [1:0]              status;
   modport source (output valid, result_num, result_den, compare_true, status, input ready);
   modport sink   (input valid, result_num, result_den, compare_true, status, output ready);
endinterface

@@ src/rational_arithmetic_unit.sv @@
// Sequence: compare modes are decided when the word is taken; arithmetic modes
// first load the operands, then run each divide, multiply and Euclid remainder
// step on the shared bit-serial divider and multiplier.
// Throughput: one word at a time; the next word is taken once the result is queued.
// Reset: synchronous, active high; clears the sequencer state and the output valid, not the
// operand register file.
module rational_arithmetic_unit (
   input logic clock,
   input logic reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);
   import rau_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_LOAD  = 11'b00000000010,
      S_FETCH = 11'b00000000100,
      S_EXEC  = 11'b00000001000,
      S_GCHK  = 11'b00000010000,
      S_DRUN  = 11'b00000100000,
      S_DFIN  = 11'b00001000000,
      S_MRUN  = 11'b00010000000,
      S_MFIN  = 11'b00100000000,
      S_WRITE = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type               state_ff, state_in;
   logic [PcW-1:0]          pc_ff, pc_in;
   logic [1:0]              ld_cnt_ff, ld_cnt_in;
   logic [StepW-1:0]        step_ff, step_in;
   logic [2:0]              mode_ff, mode_in;
   logic [DataW-1:0]        opnd_ff [4];
   logic [DataW-1:0]        rd_x_ff, rd_x_in, rd_y_ff, rd_y_in;
   logic [DataW-1:0]        res_ff, res_in;
   logic [1:0]              st_ff, st_in;
   logic                    cmp_ff, cmp_in;
   logic [DataW-1:0]        dv_ff, dv_in, quo_ff, quo_in, rem_ff, rem_in;
   logic [DataW-1:0]        mc_ff, mc_in;
   logic [2*DataW-1:0]      prod_ff, prod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DataW-1:0]        rsp_num_ff, rsp_num_in, rsp_den_ff, rsp_den_in;
   logic                    rsp_cmp_ff, rsp_cmp_in;
   logic [1:0]              rsp_st_ff, rsp_st_in;
   logic [DataW-1:0]        rf_mem [8];

   uop_type                 uop;
   logic                    accept;
   logic                    rf_we;
   logic [2:0]              rf_wa;
   logic [DataW-1:0]        rf_wd;
   logic [DataW:0]          rem_sh;
   logic                    ge;
   logic [DataW:0]          madd;
   logic [DataW-1:0]        sum;
   logic [DataW-1:0]        lim;
   logic                    neg, sub, yneg, ovf;

   assign uop       = uop_rom(pc_ff);
   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_num   = rsp_num_ff;
   assign rsp.result_den   = rsp_den_ff;
   assign rsp.compare_true = rsp_cmp_ff;
   assign rsp.status       = rsp_st_ff;

   assign rem_sh = {rem_ff, quo_ff[DataW-1]};
   assign ge     = rem_sh >= {1'b0, dv_ff};
   assign madd   = {1'b0, prod_ff[2*DataW-1:DataW]} + (prod_ff[0] ? {1'b0, mc_ff} : '0);

   always_comb begin
      sub  = (mode_ff == MODE_SUB);
      sum  = sub ? (rd_x_ff - rd_y_ff) : (rd_x_ff + rd_y_ff);
      yneg = sub ? (!rd_y_ff[DataW-1] && rd_y_ff != '0) : rd_y_ff[DataW-1];
      if (sub && rd_y_ff == SMIN) begin
         ovf = !rd_x_ff[DataW-1];
      end else begin
         ovf = (rd_x_ff[DataW-1] == yneg) && (sum[DataW-1] != rd_x_ff[DataW-1]);
      end
      neg = rd_x_ff[DataW-1] ^ rd_y_ff[DataW-1];
      lim = neg ? SMIN : SMAX;
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      ld_cnt_in    = ld_cnt_ff;
      step_in      = step_ff;
      mode_in      = mode_ff;
      rd_x_in      = rd_x_ff;
      rd_y_in      = rd_y_ff;
      res_in       = res_ff;
      st_in        = st_ff;
      cmp_in       = cmp_ff;
      dv_in        = dv_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      mc_in        = mc_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_cmp_in   = rsp_cmp_ff;
      rsp_st_in    = rsp_st_ff;
      rf_we        = 1'b0;
      rf_wa        = uop.d;
      rf_wd        = res_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in   = req.mode;
               st_in     = ST_OK;
               ld_cnt_in = '0;
               rd_x_in   = '0;
               rd_y_in   = '0;
               cmp_in    = 1'b0;
               priority case (req.mode)
                  MODE_ADD, MODE_SUB: begin
                     pc_in    = PC_ADDSUB;
                     state_in = S_LOAD;
                  end
                  MODE_MUL: begin
                     pc_in    = PC_MUL;
                     state_in = S_LOAD;
                  end
                  MODE_DIV: begin
                     pc_in    = PC_DIV;
                     state_in = S_LOAD;
                  end
                  MODE_EQ: begin
                     cmp_in   = (req.a_num == req.b_num) && (req.a_den == req.b_den);
                     state_in = S_DONE;
                  end
                  MODE_LT: begin
                     cmp_in   = (req.a_num == req.b_num) ? (req.a_den < req.b_den)
                                                         : (req.a_num < req.b_num);
                     state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_LOAD: begin
            rf_we     = 1'b1;
            rf_wa     = {1'b0, ld_cnt_ff};
            rf_wd     = opnd_ff[ld_cnt_ff];
            ld_cnt_in = ld_cnt_ff + 2'd1;
            if (ld_cnt_ff == 2'd3) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: state_in = S_EXEC;
         S_EXEC: begin
            unique case (uop.op)
               OP_GCD: state_in = S_GCHK;
               OP_DIV: begin
                  if (rd_y_ff == '0) begin
                     if (st_ff == ST_OK) st_in = ST_DIV0;
                     res_in   = '0;
                     state_in = S_WRITE;
                  end else begin
                     dv_in    = mag(rd_y_ff);
                     quo_in   = mag(rd_x_ff);
                     rem_in   = '0;
                     step_in  = '0;
                     state_in = S_DRUN;
                  end
               end
               OP_MUL: begin
                  mc_in    = mag(rd_x_ff);
                  prod_in  = {{DataW{1'b0}}, mag(rd_y_ff)};
                  step_in  = '0;
                  state_in = S_MRUN;
               end
               OP_ADD: begin
                  res_in = sum;
                  if (ovf && st_ff == ST_OK) st_in = ST_OVF;
                  state_in = S_WRITE;
               end
               OP_END: state_in = S_DONE;
               default: state_in = S_DONE;
            endcase
         end
         S_GCHK: begin
            if (rd_y_ff == '0) begin
               res_in   = rd_x_ff;
               state_in = S_WRITE;
            end else begin
               dv_in    = mag(rd_y_ff);
               quo_in   = mag(rd_x_ff);
               rem_in   = '0;
               step_in  = '0;
               state_in = S_DRUN;
            end
         end
         S_DRUN: begin
            rem_in  = ge ? (rem_sh[DataW-1:0] - dv_ff) : rem_sh[DataW-1:0];
            quo_in  = {quo_ff[DataW-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == '1) begin
               state_in = S_DFIN;
            end
         end
         S_DFIN: begin
            if (uop.op == OP_GCD) begin
               rd_x_in  = rd_y_ff;
               rd_y_in  = rd_x_ff[DataW-1] ? (~rem_ff + 1'b1) : rem_ff;
               state_in = S_GCHK;
            end else begin
               res_in = neg ? (~quo_ff + 1'b1) : quo_ff;
               if (rd_x_ff == SMIN && rd_y_ff == '1 && st_ff == ST_OK) st_in = ST_OVF;
               state_in = S_WRITE;
            end
         end
         S_MRUN: begin
            prod_in = {madd, prod_ff[DataW-1:1]};
            step_in = step_ff + 1'b1;
            if (step_ff == '1) begin
               state_in = S_MFIN;
            end
         end
         S_MFIN: begin
            res_in = neg ? (~prod_ff[DataW-1:0] + 1'b1) : prod_ff[DataW-1:0];
            if (mc_ff != '0 && (prod_ff[2*DataW-1:DataW] != '0 || prod_ff[DataW-1:0] > lim)
                && st_ff == ST_OK) begin
               st_in = ST_OVF;
            end
            state_in = S_WRITE;
         end
         S_WRITE: begin
            rf_we    = 1'b1;
            pc_in    = pc_ff + 1'b1;
            state_in = S_FETCH;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = (st_ff != ST_OK) ? '0 : rd_x_ff;
               rsp_den_in   = (st_ff != ST_OK) ? '0 : rd_y_ff;
               rsp_cmp_in   = cmp_ff;
               rsp_st_in    = st_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_wa] <= rf_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FETCH) begin
         rd_x_ff <= rf_mem[uop.x];
         rd_y_ff <= rf_mem[uop.y];
      end else begin
         rd_x_ff <= rd_x_in;
         rd_y_ff <= rd_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         opnd_ff[0] <= req.a_num;
         opnd_ff[1] <= req.a_den;
         opnd_ff[2] <= req.b_num;
         opnd_ff[3] <= req.b_den;
      end
      pc_ff      <= pc_in;
      ld_cnt_ff  <= ld_cnt_in;
      step_ff    <= step_in;
      mode_ff    <= mode_in;
      res_ff     <= res_in;
      st_ff      <= st_in;
      cmp_ff     <= cmp_in;
      dv_ff      <= dv_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      mc_ff      <= mc_in;
      prod_ff    <= prod_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_cmp_ff <= rsp_cmp_in;
      rsp_st_ff  <= rsp_st_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_st_ff != ST_OK |-> rsp_num_ff == '0 && rsp_den_ff == '0)
      else $error("faulted word carries a nonzero fraction");

   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_cmp_ff |-> rsp_st_ff == ST_OK && rsp_num_ff == '0)
      else $error("compare word carries arithmetic data");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("sequencer idle right after taking a word");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DRUN && step_ff != '1 |=> state_ff == S_DRUN)
      else $error("divider left its run early");

   a_load_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOAD && ld_cnt_ff != 2'd3 |=> state_ff == S_LOAD)
      else $error("operand load cut short");

endmodule
